[design/rbu_pkg.sv]
// rbu_pkg: shared widths, limits and status codes of the rle block unpacker
// used by rle_block_unpacker_top, rbu_checker and tb, no dependencies
package rbu_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned LEN_W       = 17;
  localparam int unsigned MAX_BLOCK   = 65536;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 48;
  localparam int unsigned OUT_TUSER_W = 2;

  localparam logic [LEN_W-1:0]  DEST_LEN_RST = LEN_W'(16384);
  localparam logic [BYTE_W-1:0] LIT_FLAG     = BYTE_W'(8'h80);
  localparam logic [BYTE_W-1:0] LIT_MASK     = BYTE_W'(8'h7F);
  localparam logic [BYTE_W-1:0] REP_BIAS     = BYTE_W'(3);

  typedef enum logic [OUT_TUSER_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_LEN  = 2'd1,
    STAT_LEFTOVER = 2'd2
  } status_t;

endpackage

[design/rle_block_unpacker_top.sv]
// rle_block_unpacker_top: packbits style run decoder, one source byte per item
// depends on rbu_pkg
// result path: input register, then result register; a stalled result side can hold an item between them
// throughput: one item per cycle while the result side does not stall; the parser state updates per item
// an item with no run and not last gives no result and needs no result slot
// reset: synchronous active low rst_n clears all block state, dest_len returns to 16384
module rle_block_unpacker_top (
  input  logic                               clk,
  input  logic                               rst_n,
  // cfg_data: dest_len
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rbu_pkg::LEN_W-1:0]          cfg_data,
  // in_tdata: src_byte [7:0], block_src_len [24:8], zero fill
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [rbu_pkg::IN_TDATA_W-1:0]     in_tdata,
  // out_tdata: run_value [7:0], run_count [24:8], produced_len [41:25], zero fill
  // out_tuser: status [1:0]; out_tlast: done_res
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [rbu_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                               out_tlast,
  output logic [rbu_pkg::OUT_TUSER_W-1:0]    out_tuser
);

  localparam int unsigned LW = rbu_pkg::LEN_W;
  localparam int unsigned BW = rbu_pkg::BYTE_W;

  typedef enum logic [1:0] {
    MODE_PACKED = 2'd0,
    MODE_FILL   = 2'd1,
    MODE_COPY   = 2'd2,
    MODE_REJECT = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_LITERAL = 2'd1,
    PH_REPEAT  = 2'd2
  } phase_t;

  logic [LW-1:0] dest_len_r;

  logic          s1_valid_r;
  logic [BW-1:0] s1_byte_r;
  logic [LW-1:0] s1_slen_r;

  logic [LW-1:0] src_pos_r, src_pos_nxt;
  logic [LW-1:0] dst_pos_r, dst_pos_nxt;
  mode_t         mode_r, mode_nxt;
  phase_t        phase_r, phase_nxt;
  logic [BW-1:0] lit_r, lit_nxt;
  logic [BW-1:0] rep_r, rep_nxt;
  logic          ovf_r, ovf_nxt;

  logic                         out_valid_r;
  logic [rbu_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                         out_last_r;
  logic [rbu_pkg::OUT_TUSER_W-1:0] out_user_r, out_user_nxt;

  logic          first, last, have_run, has_res, out_free, s1_fire;
  mode_t         mode_eff;
  phase_t        phase_eff;
  logic [LW-1:0] room, cnt, dst_upd, prod;
  logic [BW-1:0] val;
  rbu_pkg::status_t stat;

  assign cfg_ready  = 1'b1;
  assign out_free   = !out_valid_r || out_tready;
  assign has_res    = have_run || last;
  assign s1_fire    = s1_valid_r && (!has_res || out_free);
  assign in_tready  = !s1_valid_r || s1_fire;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

  always_comb begin
    first = (src_pos_r == '0);
    if (first) begin
      phase_eff = PH_HEADER;
      if (s1_slen_r == '0 || dest_len_r == '0 || dest_len_r < s1_slen_r ||
          32'(dest_len_r) > rbu_pkg::MAX_BLOCK) begin
        mode_eff = MODE_REJECT;
      end else if (s1_slen_r == LW'(1)) begin
        mode_eff = MODE_FILL;
      end else if (s1_slen_r == dest_len_r) begin
        mode_eff = MODE_COPY;
      end else begin
        mode_eff = MODE_PACKED;
      end
    end else begin
      phase_eff = phase_r;
      mode_eff  = mode_r;
    end

    last = ({1'b0, src_pos_r} + (LW+1)'(1)) >= {1'b0, s1_slen_r};
    room = (dst_pos_r < dest_len_r) ? (dest_len_r - dst_pos_r) : '0;

    have_run  = 1'b0;
    val       = '0;
    cnt       = '0;
    phase_nxt = phase_eff;
    lit_nxt   = lit_r;
    rep_nxt   = rep_r;
    ovf_nxt   = ovf_r;

    unique case (mode_eff)
      MODE_REJECT: begin
      end
      MODE_FILL: begin
        if (first && room != '0) begin
          have_run = 1'b1;
          val      = s1_byte_r;
          cnt      = room;
        end else begin
          ovf_nxt = 1'b1;
        end
      end
      MODE_COPY: begin
        if (room != '0) begin
          have_run = 1'b1;
          val      = s1_byte_r;
          cnt      = LW'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
      end
      default: begin
        if (room == '0) begin
          ovf_nxt = 1'b1;
        end else begin
          unique case (phase_eff)
            PH_LITERAL: begin
              have_run = 1'b1;
              val      = s1_byte_r;
              cnt      = LW'(1);
              lit_nxt  = lit_r - BW'(1);
              if (lit_nxt == '0) begin
                phase_nxt = PH_HEADER;
              end
            end
            PH_REPEAT: begin
              have_run  = 1'b1;
              val       = s1_byte_r;
              cnt       = (LW'(rep_r) < room) ? LW'(rep_r) : room;
              phase_nxt = PH_HEADER;
            end
            default: begin
              if ((s1_byte_r & rbu_pkg::LIT_FLAG) != '0) begin
                lit_nxt   = (s1_byte_r & rbu_pkg::LIT_MASK) + BW'(1);
                phase_nxt = PH_LITERAL;
              end else begin
                rep_nxt   = s1_byte_r + rbu_pkg::REP_BIAS;
                phase_nxt = PH_REPEAT;
              end
            end
          endcase
        end
      end
    endcase

    dst_upd = have_run ? (dst_pos_r + cnt) : dst_pos_r;

    priority if (mode_eff == MODE_REJECT) begin
      stat = rbu_pkg::STAT_BAD_LEN;
    end else if (ovf_nxt) begin
      stat = rbu_pkg::STAT_LEFTOVER;
    end else begin
      stat = rbu_pkg::STAT_OK;
    end
    prod = (last && mode_eff != MODE_REJECT) ? dst_upd : '0;

    out_user_nxt = last ? stat : rbu_pkg::STAT_OK;
    out_data_nxt = {(rbu_pkg::OUT_TDATA_W - BW - 2*LW)'(0), prod, cnt, val};

    if (last) begin
      src_pos_nxt = '0;
      dst_pos_nxt = '0;
      mode_nxt    = MODE_PACKED;
    end else begin
      src_pos_nxt = src_pos_r + LW'(1);
      dst_pos_nxt = dst_upd;
      mode_nxt    = mode_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_len_r  <= rbu_pkg::DEST_LEN_RST;
      s1_valid_r  <= 1'b0;
      src_pos_r   <= '0;
      dst_pos_r   <= '0;
      mode_r      <= MODE_PACKED;
      phase_r     <= PH_HEADER;
      lit_r       <= '0;
      rep_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        dest_len_r <= cfg_data;
      end
      if (in_tvalid && in_tready) begin
        s1_valid_r <= 1'b1;
        s1_byte_r  <= in_tdata[BW-1:0];
        s1_slen_r  <= in_tdata[BW+LW-1:BW];
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        src_pos_r <= src_pos_nxt;
        dst_pos_r <= dst_pos_nxt;
        mode_r    <= mode_nxt;
        if (last) begin
          phase_r <= PH_HEADER;
          lit_r   <= '0;
          rep_r   <= '0;
          ovf_r   <= 1'b0;
        end else begin
          phase_r <= phase_nxt;
          lit_r   <= lit_nxt;
          rep_r   <= rep_nxt;
          ovf_r   <= ovf_nxt;
        end
      end
      if (s1_fire && has_res) begin
        out_valid_r <= 1'b1;
        out_data_r  <= out_data_nxt;
        out_last_r  <= last;
        out_user_r  <= out_user_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

[design/rbu_checker.sv]
// rbu_checker: port level checks of rle_block_unpacker_top, bound to the top level
// depends on rbu_pkg and rle_block_unpacker_top
module rbu_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [rbu_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input logic                               out_tlast,
  input logic [rbu_pkg::OUT_TUSER_W-1:0]    out_tuser
);

  // stalled item holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tlast) && $stable(out_tuser))
    else $error("result item changed while stalled");

  // items before the block end carry no status and no total, and a nonempty run
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tuser == rbu_pkg::STAT_OK &&
      out_tdata[41:25] == '0 && out_tdata[24:8] != '0)
    else $error("mid block item with status, total or empty run");

  // rejected blocks report no run and no total
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == rbu_pkg::STAT_BAD_LEN |->
      out_tdata[24:8] == '0 && out_tdata[41:25] == '0)
    else $error("rejected block reported a run or a total");

  // empty run has zero value
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[24:8] == '0 |-> out_tdata[7:0] == '0)
    else $error("empty run with nonzero value");

  // status codes only on the block end
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != rbu_pkg::STAT_OK |-> out_tlast)
    else $error("status on an item that is not the block end");

endmodule

bind rle_block_unpacker_top rbu_checker u_rbu_checker (.*);

[tb/tb.sv]
// tb: self-checking testbench for rle_block_unpacker_top, predicts every run item
// and compares it field by field; depends on rbu_pkg and rle_block_unpacker_top
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_ITEMS = 1050;
  localparam int unsigned PHASE_ITEMS  = 110;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned LIMIT_CYCLES = 400000;

  typedef enum logic [1:0] {MODE_PACKED, MODE_FILL, MODE_COPY, MODE_REJECT} blk_mode_t;
  typedef enum logic [1:0] {PH_HEADER, PH_LITERAL, PH_REPEAT} parse_ph_t;

  typedef struct packed {
    logic [rbu_pkg::BYTE_W-1:0] value;
    logic [rbu_pkg::LEN_W-1:0]  count;
    logic                       done;
    rbu_pkg::status_t           status;
    logic [rbu_pkg::LEN_W-1:0]  produced;
  } run_desc_t;

  typedef logic [rbu_pkg::BYTE_W-1:0] byte_q_t[$];

  class run_scoreboard;
    logic [rbu_pkg::LEN_W-1:0]  dest_len;
    logic [rbu_pkg::LEN_W-1:0]  src_pos;
    logic [rbu_pkg::LEN_W-1:0]  dst_pos;
    blk_mode_t                  mode;
    parse_ph_t                  phase;
    logic [rbu_pkg::BYTE_W-1:0] lit_left;
    logic [rbu_pkg::BYTE_W-1:0] rep_len;
    bit                         overflow;
    run_desc_t                  expected_runs[$];
    int unsigned                errors;

    function new();
      dest_len = rbu_pkg::DEST_LEN_RST;
      errors   = 0;
      clear_block();
    endfunction

    function void clear_block();
      src_pos  = '0;
      dst_pos  = '0;
      mode     = MODE_PACKED;
      phase    = PH_HEADER;
      lit_left = '0;
      rep_len  = '0;
      overflow = 1'b0;
    endfunction

    function void note_input(logic [rbu_pkg::BYTE_W-1:0] b, logic [rbu_pkg::LEN_W-1:0] slen);
      logic [rbu_pkg::LEN_W-1:0]  room;
      logic [rbu_pkg::LEN_W-1:0]  cnt;
      logic [rbu_pkg::BYTE_W-1:0] val;
      bit                         have_run;
      bit                         last;
      run_desc_t                  r;
      cnt      = '0;
      val      = '0;
      have_run = 1'b0;
      if (src_pos == 0) begin
        if (slen == 0 || dest_len == 0 || dest_len < slen || dest_len > rbu_pkg::MAX_BLOCK)
          mode = MODE_REJECT;
        else if (slen == 1)
          mode = MODE_FILL;
        else if (slen == dest_len)
          mode = MODE_COPY;
        else
          mode = MODE_PACKED;
        phase = PH_HEADER;
      end
      last = ({1'b0, src_pos} + 18'd1) >= {1'b0, slen};
      room = (dst_pos < dest_len) ? dest_len - dst_pos : '0;

      case (mode)
        MODE_REJECT: ;
        MODE_FILL: begin
          if (src_pos == 0 && room > 0) begin
            have_run = 1'b1;
            val      = b;
            cnt      = room;
          end else begin
            overflow = 1'b1;
          end
        end
        MODE_COPY: begin
          if (room > 0) begin
            have_run = 1'b1;
            val      = b;
            cnt      = rbu_pkg::LEN_W'(1);
          end else begin
            overflow = 1'b1;
          end
        end
        default: begin
          if (room == 0) begin
            overflow = 1'b1;
          end else if (phase == PH_LITERAL) begin
            have_run = 1'b1;
            val      = b;
            cnt      = rbu_pkg::LEN_W'(1);
            lit_left = lit_left - 8'd1;
            if (lit_left == 0) phase = PH_HEADER;
          end else if (phase == PH_REPEAT) begin
            have_run = 1'b1;
            val      = b;
            cnt      = (rbu_pkg::LEN_W'(rep_len) < room) ? rbu_pkg::LEN_W'(rep_len) : room;
            phase    = PH_HEADER;
          end else if ((b & rbu_pkg::LIT_FLAG) != 0) begin
            lit_left = (b & rbu_pkg::LIT_MASK) + 8'd1;
            phase    = PH_LITERAL;
          end else begin
            rep_len = b + rbu_pkg::REP_BIAS;
            phase   = PH_REPEAT;
          end
        end
      endcase

      if (have_run) dst_pos = dst_pos + cnt;
      src_pos = src_pos + rbu_pkg::LEN_W'(1);
      if (!last && !have_run) return;

      r.value    = val;
      r.count    = cnt;
      r.done     = last;
      r.status   = rbu_pkg::STAT_OK;
      r.produced = '0;
      if (last) begin
        if (mode == MODE_REJECT)
          r.status = rbu_pkg::STAT_BAD_LEN;
        else if (overflow)
          r.status = rbu_pkg::STAT_LEFTOVER;
        r.produced = (mode == MODE_REJECT) ? '0 : dst_pos;
        clear_block();
      end
      expected_runs.push_back(r);
    endfunction

    function void check_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(logic [rbu_pkg::OUT_TDATA_W-1:0] tdata, logic tlast,
                               logic [rbu_pkg::OUT_TUSER_W-1:0] tuser);
      run_desc_t r;
      if (expected_runs.size() == 0) begin
        $error("result item with none expected: tdata %h tlast %b tuser %0d",
               tdata, tlast, tuser);
        errors++;
        return;
      end
      r = expected_runs.pop_front();
      check_field("run_value", 32'(r.value), 32'(tdata[7:0]));
      check_field("run_count", 32'(r.count), 32'(tdata[24:8]));
      check_field("produced_len", 32'(r.produced), 32'(tdata[41:25]));
      check_field("tdata zero fill", 0, 32'(tdata[47:42]));
      check_field("done_res", 32'(r.done), 32'(tlast));
      check_field("status", 32'(r.status), 32'(tuser));
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n      = 1'b0;
  logic                            cfg_valid  = 1'b0;
  logic                            cfg_ready;
  logic [rbu_pkg::LEN_W-1:0]       cfg_data   = '0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [rbu_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [rbu_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            out_tlast;
  logic [rbu_pkg::OUT_TUSER_W-1:0] out_tuser;

  run_scoreboard sb = new();

  int unsigned tx_idle_pct = 11;
  int unsigned rx_idle_pct = 54;
  int unsigned items_sent  = 0;
  int unsigned cycles      = 0;
  bit          hold_req    = 1'b0;

  rle_block_unpacker_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.dest_len = cfg_data;
      if (in_tvalid && in_tready) sb.note_input(in_tdata[7:0], in_tdata[24:8]);
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast, out_tuser);
    end
  end

  // result side back-pressure, with one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_item(input logic [rbu_pkg::BYTE_W-1:0] b,
                           input logic [rbu_pkg::LEN_W-1:0] slen);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, slen, b};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_bytes(input byte_q_t blk);
    foreach (blk[i]) send_item(blk[i], rbu_pkg::LEN_W'(blk.size()));
  endtask

  // first item carries one length, the rest another, as the block reads it live
  task automatic send_split_block(input logic [rbu_pkg::LEN_W-1:0] first_len,
                                  input logic [rbu_pkg::LEN_W-1:0] rest_len);
    int unsigned i;
    send_item(rbu_pkg::BYTE_W'($urandom), first_len);
    if (first_len > 1) begin
      i = 1;
      send_item(rbu_pkg::BYTE_W'($urandom), rest_len);
      while (i + 1 < rest_len) begin
        i++;
        send_item(rbu_pkg::BYTE_W'($urandom), rest_len);
      end
    end
  endtask

  task automatic send_packed_block(input int unsigned target);
    byte_q_t     blk;
    int unsigned n;
    int unsigned keep;
    while (blk.size() < target) begin
      if ($urandom_range(1) == 1) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(128, 1) : $urandom_range(6, 1);
        blk.push_back(rbu_pkg::LIT_FLAG | rbu_pkg::BYTE_W'(n - 1));
        repeat (n) blk.push_back(rbu_pkg::BYTE_W'($urandom));
      end else begin
        blk.push_back(rbu_pkg::BYTE_W'($urandom_range(127)));
        blk.push_back(rbu_pkg::BYTE_W'($urandom));
      end
    end
    // cut some blocks short at a random point, possibly inside a run
    if ($urandom_range(4) == 0) begin
      keep = $urandom_range(blk.size(), 1);
      while (blk.size() > keep) blk.delete(blk.size() - 1);
    end
    send_bytes(blk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_runs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_dest_len(input logic [rbu_pkg::LEN_W-1:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    byte_q_t                   pattern;
    int unsigned               rnd_start;
    int unsigned               phase_start;
    int unsigned               phase_no;
    int unsigned               done_rnd;
    int unsigned               pick;
    logic [rbu_pkg::LEN_W-1:0] dlen;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill with reset length, then fill the largest destination
    send_item(8'hFF, 17'd1);
    write_dest_len(17'd65536);
    send_item(8'h00, 17'd1);
    // raw copy chosen with the largest source length, length then changed
    send_split_block(17'd65536, 17'd3);
    send_item(8'h00, 17'd65535);
    send_item(8'hC3, 17'd2);
    // zero destination rejects
    write_dest_len(17'd0);
    send_item(8'h5A, 17'd1);
    // literal, repeat, then a literal cut short
    write_dest_len(17'd8);
    pattern = '{8'h80, 8'hAA, 8'h00, 8'h55, 8'hFF, 8'h11};
    send_bytes(pattern);
    // longest repeat clipped, then left over bytes
    pattern = '{8'h7F, 8'h33, 8'h01, 8'h02, 8'h03};
    send_bytes(pattern);
    // source longer than destination
    send_item(8'h12, 17'd9);
    send_item(8'h34, 17'd2);
    // block ends on a repeat header
    pattern = '{8'h80, 8'h01, 8'h02};
    send_bytes(pattern);

    rnd_start = items_sent;
    phase_no  = 0;
    while (items_sent - rnd_start < RANDOM_ITEMS) begin
      case (phase_no % 5)
        0: dlen = rbu_pkg::LEN_W'($urandom_range(300, 16));
        1: dlen = rbu_pkg::LEN_W'($urandom_range(64, 2));
        2: dlen = 17'd65536;
        3: dlen = 17'd1;
        default: dlen = 17'h0FFFF;
      endcase
      write_dest_len(dlen);
      if (phase_no == 1) hold_req = 1'b1;
      if (phase_no == 6) begin
        send_packed_block($urandom_range(40, 2));
        wait_drained();
      end
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS &&
             items_sent - rnd_start < RANDOM_ITEMS) begin
        done_rnd = items_sent - rnd_start;
        if (done_rnd < RANDOM_ITEMS / 3) begin
          tx_idle_pct = 11;
          rx_idle_pct = 54;
        end else if (done_rnd < 2 * RANDOM_ITEMS / 3) begin
          tx_idle_pct = 54;
          rx_idle_pct = 11;
        end else begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
        pick = $urandom_range(99);
        if (pick < 65)
          send_packed_block($urandom_range(40, 2));
        else if (pick < 75)
          send_split_block(dlen, rbu_pkg::LEN_W'((dlen <= 48) ?
                           dlen + (($urandom_range(3) == 0) ? $urandom_range(3, 1) : 0) :
                           $urandom_range(8, 1)));
        else if (pick < 80)
          send_item(rbu_pkg::BYTE_W'($urandom), 17'd1);
        else
          send_split_block(rbu_pkg::LEN_W'($urandom_range(65536, 1)),
                           rbu_pkg::LEN_W'($urandom_range(12, 1)));
      end
      phase_no++;
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_runs.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule

[rle_block_unpacker_top.f]
design/rbu_pkg.sv
design/rle_block_unpacker_top.sv
design/rbu_checker.sv
tb/tb.sv
